// ----- src/dsw_pkg.sv -----
`timescale 1ns / 1ps

package dsw_pkg;

	// Format kinds carried by a request.
	localparam logic [2:0] KIND_HEX = 3'd0;
	localparam logic [2:0] KIND_U8  = 3'd1;
	localparam logic [2:0] KIND_S8  = 3'd2;
	localparam logic [2:0] KIND_U16 = 3'd3;
	localparam logic [2:0] KIND_S16 = 3'd4;

	// Highest digit register written by each decimal kind.
	localparam logic [2:0] TOP_U8  = 3'd3;
	localparam logic [2:0] TOP_S8  = 3'd4;
	localparam logic [2:0] TOP_U16 = 3'd5;
	localparam logic [2:0] TOP_S16 = 3'd6;

	// Segment patterns that are not digits.
	localparam logic [7:0] MINUS_GLYPH = 8'h01;
	localparam logic [7:0] BLANK_GLYPH = 8'h00;

	// Reciprocal of ten, exact for every 16-bit dividend.
	localparam logic [15:0] RECIP_TEN  = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	// Queue between front and back; depth is a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] value;
		logic [7:0]  digit_position;
	} request_t;

	typedef struct packed {
		logic [7:0] digit_register;
		logic [7:0] segment_pattern;
		logic       last;
	} result_t;

	// One classified job as it waits in the queue.
	typedef struct packed {
		logic        is_hex;
		logic [7:0]  hex_register;
		logic [7:0]  hex_pattern;
		logic [15:0] magnitude;
		logic        negative;
		logic [2:0]  top;
	} job_t;

	// Glyph for one hexadecimal digit, order DP A B C D E F G.
	function automatic logic [7:0] glyph(input logic [3:0] digit);
		logic [7:0] pat;
		case (digit)
			4'h0: pat = 8'h7E;
			4'h1: pat = 8'h30;
			4'h2: pat = 8'h6D;
			4'h3: pat = 8'h79;
			4'h4: pat = 8'h33;
			4'h5: pat = 8'h5B;
			4'h6: pat = 8'h5F;
			4'h7: pat = 8'h70;
			4'h8: pat = 8'h7F;
			4'h9: pat = 8'h7B;
			4'hA: pat = 8'h77;
			4'hB: pat = 8'h1F;
			4'hC: pat = 8'h4E;
			4'hD: pat = 8'h3D;
			4'hE: pat = 8'h4F;
			default: pat = 8'h47;
		endcase
		return pat;
	endfunction

endpackage

// ----- src/decimal_to_seven_segment_writes.sv -----
`timescale 1ns / 1ps
// The first write of a request passes through the queue, the back-end job registers and the
// output register. One digit-register write per cycle while work is queued; a hex request gives
// one write, decimal kinds one per register from one up to the top, stepped by the back-end sequencer.
// A two-entry queue lets a new request be taken while the back end still works on older ones.
// The receiver cannot stall; results are strobed for one cycle each. Unused kinds give none.
// Reset (arst_n low, asynchronous) empties the queue and clears the strobe; no clearing pass.

module decimal_to_seven_segment_writes (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dsw_pkg::request_t request,
	output logic              strobe,
	output dsw_pkg::result_t  result
);
	import dsw_pkg::*;

	logic take;
	logic push;
	job_t push_job;
	logic pop;
	logic empty;
	logic full;
	job_t head;

	assign busy = full;
	assign take = start && !full;

	// Front end: classify the request.
	dsw_front u_front (
		.request (request),
		.take    (take),
		.push    (push),
		.job     (push_job)
	);

	// Queue between front and back.
	dsw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.empty    (empty),
		.full     (full),
		.head     (head)
	);

	// Back end: issue the register writes.
	dsw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ----- src/dsw_front.sv -----
`timescale 1ns / 1ps

module dsw_front (
	input  dsw_pkg::request_t request,
	input  logic              take,
	output logic              push,
	output dsw_pkg::job_t     job
);
	import dsw_pkg::*;

	// Classify the request: magnitude, sign and top register per kind.
	always_comb begin
		job              = '0;
		job.hex_register = request.digit_position;
		job.hex_pattern  = (request.value[15:4] == 12'd0) ? glyph(request.value[3:0])
		                                                  : BLANK_GLYPH;
		push             = take;
		case (request.kind)
			KIND_HEX: begin
				job.is_hex = 1'b1;
			end
			KIND_U8: begin
				job.magnitude = {8'd0, request.value[7:0]};
				job.top       = TOP_U8;
			end
			KIND_S8: begin
				job.negative  = request.value[7];
				job.magnitude = request.value[7]
				                ? {8'd0, 8'(~request.value[7:0] + 8'd1)}
				                : {8'd0, request.value[7:0]};
				job.top       = TOP_S8;
			end
			KIND_U16: begin
				job.magnitude = request.value;
				job.top       = TOP_U16;
			end
			KIND_S16: begin
				job.negative  = request.value[15];
				job.magnitude = request.value[15] ? 16'(~request.value + 16'd1)
				                                  : request.value;
				job.top       = TOP_S16;
			end
			default: begin
				// Unused kinds are dropped here and cause no writes.
				push = 1'b0;
			end
		endcase
	end

endmodule

// ----- src/dsw_queue.sv -----
`timescale 1ns / 1ps

module dsw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dsw_pkg::job_t push_job,
	input  logic          pop,
	output logic          empty,
	output logic          full,
	output dsw_pkg::job_t head
);
	import dsw_pkg::*;

	job_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- src/dsw_back.sv -----
`timescale 1ns / 1ps

module dsw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  dsw_pkg::job_t    head,
	output logic             pop,
	output logic             strobe,
	output dsw_pkg::result_t result
);
	import dsw_pkg::*;

	logic        active_q;
	logic        strobe_q;
	result_t     result_q;
	logic        is_hex_q;
	logic [7:0]  hex_register_q;
	logic [7:0]  hex_pattern_q;
	logic [15:0] mag_q;
	logic        neg_q;
	logic [2:0]  top_q;
	logic [2:0]  reg_q;
	logic        digits_done_q;
	logic        minus_done_q;

	logic [31:0] product;
	logic [15:0] quotient;
	logic [15:0] remainder;
	result_t     write_d;
	logic        write_last;

	// Divide the running magnitude by ten with a reciprocal multiply.
	always_comb begin
		product   = 32'(mag_q) * 32'(RECIP_TEN);
		quotient  = 16'(product >> RECIP_SHIFT);
		remainder = mag_q - 16'((quotient << 3) + (quotient << 1));
	end

	// Select the write for this cycle: hex glyph, digit, minus or blank.
	always_comb begin
		if (is_hex_q) begin
			write_d.digit_register  = hex_register_q;
			write_d.segment_pattern = hex_pattern_q;
			write_d.last            = 1'b1;
		end else begin
			write_d.digit_register = {5'd0, reg_q};
			write_d.last           = (reg_q == top_q);
			if (!digits_done_q) begin
				write_d.segment_pattern = glyph(remainder[3:0]);
			end else if (neg_q && !minus_done_q) begin
				write_d.segment_pattern = MINUS_GLYPH;
			end else begin
				write_d.segment_pattern = BLANK_GLYPH;
			end
		end
		write_last = active_q && write_d.last;
		pop        = !empty && (!active_q || write_last);
	end

	// Job and output control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			active_q <= pop || (active_q && !write_last);
			strobe_q <= active_q;
		end
	end

	// Job registers: load from the queue, then step one register per cycle.
	always_ff @(posedge clk) begin
		if (active_q) begin
			result_q <= write_d;
		end
		if (pop) begin
			is_hex_q       <= head.is_hex;
			hex_register_q <= head.hex_register;
			hex_pattern_q  <= head.hex_pattern;
			mag_q          <= head.magnitude;
			neg_q          <= head.negative;
			top_q          <= head.top;
			reg_q          <= 3'd1;
			digits_done_q  <= 1'b0;
			minus_done_q   <= 1'b0;
		end else if (active_q) begin
			mag_q         <= quotient;
			reg_q         <= reg_q + 3'd1;
			digits_done_q <= digits_done_q || (quotient == 16'd0);
			minus_done_q  <= minus_done_q || (digits_done_q && neg_q);
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ----- src/dsw_checker.sv -----
`timescale 1ns / 1ps

module dsw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              strobe,
	input dsw_pkg::result_t  result
);
	import dsw_pkg::*;

	// A decimal burst continues without gaps until its last write.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("write burst broken before its last write");

	// Within a burst the register address climbs by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> result.digit_register == $past(result.digit_register) + 8'd1)
		else $error("digit register did not advance by one");

	// A write that is not the last belongs to a decimal burst, registers one to five.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> result.digit_register >= 8'd1 && result.digit_register <= 8'd5)
		else $error("non-final write outside decimal register range");

	// No glyph lights the decimal point.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !result.segment_pattern[7])
		else $error("decimal point segment set");

endmodule

bind decimal_to_seven_segment_writes dsw_checker u_dsw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.strobe  (strobe),
	.result  (result)
);
